// File: rtl/prfa_pkg.sv
// ----------------------------------------------------------------------------
// Pairwise repulsive force accumulator package
// Shared widths, register indexes and reset values of the force accumulator.
// ----------------------------------------------------------------------------
package prfa_pkg;

    // Default fraction bits of the position format (Q8.24).
    localparam int PRFA_POS_FRAC_BITS = 24;

    localparam int POS_W     = 32;   // position and distance width
    localparam int CFG_W     = 32;   // widest configuration register
    localparam int CFG_IDX_W = 2;    // configuration index width
    localparam int ACC_W     = 64;   // acceleration sum width

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_DIST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_MASS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_CUTOFF_DIST   = 32'd167772;
    localparam logic [CFG_W-1:0] RST_MIN_DIST      = 32'd1678;
    localparam logic [CFG_W-1:0] RST_PARTICLE_MASS = 32'd167772;

endpackage

// File: rtl/pair_repulsive_force_accumulate.sv
// ----------------------------------------------------------------------------
// Pairwise repulsive force accumulator
// Adds the short-range force of one neighbour pair per transfer to a running
// saturating acceleration and hands out the sums on the last pair of a run.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  -------   ---------  ------------------------------------------------------
//  s_axis    in         tdata: self_x, self_y, other_x, other_y; tuser:
//                       first_pair; tlast: last_pair
//  m_axis    out        tdata: accel_x_out, accel_y_out; tuser: saturated
//  i_cfg_*   in         index 0 cutoff_dist, 1 min_dist, 2 particle_mass
//
// A pair outside the cutoff ends after the cutoff test. A pair inside it needs
// up to eight products on the shared 32x32 multiplier, 32 steps of the
// bit-serial square root, and up to four passes of the shared restoring
// divider at one quotient bit per cycle. The slave side is ready only while
// the sequencer is idle. A result waits in the output register; the next
// pair is taken meanwhile, and the sequencer holds at its final step only
// if a second result arrives before the first has been taken. Reset
// restores the register defaults and clears the sums.
// ----------------------------------------------------------------------------
module pair_repulsive_force_accumulate
    import prfa_pkg::*;
#(
    parameter int POS_FRAC_BITS = PRFA_POS_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Pair input.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [4*POS_W-1:0]   s_axis_tdata,   // self_x, self_y, other_x, other_y
    input  logic                 s_axis_tuser,   // first_pair
    input  logic                 s_axis_tlast,   // last_pair
    // Result output.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*ACC_W-1:0]   m_axis_tdata,   // accel_x_out, accel_y_out
    output logic                 m_axis_tuser,   // saturated
    // Configuration writes.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Sequencer steps.
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_DX2   = 5'd1;
    localparam logic [4:0] ST_DY2   = 5'd2;
    localparam logic [4:0] ST_C2    = 5'd3;
    localparam logic [4:0] ST_M2    = 5'd4;
    localparam logic [4:0] ST_R2    = 5'd5;
    localparam logic [4:0] ST_CLAMP = 5'd6;
    localparam logic [4:0] ST_SQRT  = 5'd7;
    localparam logic [4:0] ST_COEF  = 5'd8;
    localparam logic [4:0] ST_DCHK  = 5'd9;
    localparam logic [4:0] ST_DIV   = 5'd10;
    localparam logic [4:0] ST_DPOST = 5'd11;
    localparam logic [4:0] ST_AXIS  = 5'd12;
    localparam logic [4:0] ST_PLO   = 5'd13;
    localparam logic [4:0] ST_PHI   = 5'd14;
    localparam logic [4:0] ST_PADD  = 5'd15;
    localparam logic [4:0] ST_ACC   = 5'd16;
    localparam logic [4:0] ST_DONE  = 5'd17;

    // What the divider is working on.
    localparam logic [1:0] OP_K = 2'd0;
    localparam logic [1:0] OP_E = 2'd1;
    localparam logic [1:0] OP_M = 2'd2;

    localparam logic signed [ACC_W+1:0] SUM_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W+1:0] SUM_MIN = -66'sh0_8000_0000_0000_0000;

    // Configuration.
    logic [CFG_W-1:0]     r_cutoff;
    logic [CFG_W-1:0]     r_min;
    logic [CFG_W-1:0]     r_mass;

    // Control.
    logic [4:0]           r_state;
    logic [1:0]           r_op;
    logic                 r_axis;
    logic [5:0]           r_cnt;
    logic                 r_ovalid;

    // Pair payload and intermediate values.
    logic [POS_W-1:0]     r_dxm;
    logic [POS_W-1:0]     r_dym;
    logic                 r_xneg;
    logic                 r_yneg;
    logic                 r_last;
    logic [63:0]          r_prod;
    logic [63:0]          r_dx2;
    logic [63:0]          r_dy2;
    logic [63:0]          r_c2;
    logic [63:0]          r_m2;
    logic [64:0]          r_sum2;
    logic [63:0]          r_r2;
    logic                 r_coef_neg;
    logic [63:0]          r_e;
    logic                 r_eovf;

    // Shared divider and square root registers.
    logic [127:0]         r_num;
    logic [63:0]          r_den;
    logic [63:0]          r_rem;
    logic [63:0]          r_quo;
    logic [63:0]          r_bit;
    logic                 r_dovf;

    // Accumulator state and output register.
    logic [ACC_W-1:0]     r_sum_ax;
    logic [ACC_W-1:0]     r_sum_ay;
    logic                 r_sat;
    logic [2*ACC_W-1:0]   r_odata;
    logic                 r_osat;

    // Input unpacking.
    logic [POS_W-1:0]     in_sx;
    logic [POS_W-1:0]     in_sy;
    logic [POS_W-1:0]     in_ox;
    logic [POS_W-1:0]     in_oy;
    logic                 in_accept;

    // Combinational helpers.
    logic [POS_W-1:0]     mul_a;
    logic [POS_W-1:0]     mul_b;
    logic [POS_W-1:0]     axis_d;
    logic [63:0]          div_sh;
    logic                 div_ge;
    logic [63:0]          sq_t;
    logic                 sq_ge;
    logic                 clamp_lo;
    logic [63:0]          clamp_r2;
    logic                 clamp_in;
    logic [POS_W-1:0]     coef_r;
    logic                 coef_neg;
    logic [POS_W-1:0]     coef_diff;
    logic [64:0]          padd_sum;
    logic [ACC_W-1:0]     acc_sum;
    logic                 acc_neg;
    logic signed [ACC_W+1:0] acc_ext;
    logic signed [ACC_W+1:0] acc_mag;
    logic signed [ACC_W+1:0] acc_t;
    logic                 acc_ovf;
    logic [ACC_W-1:0]     acc_new;
    logic                 out_free;

    assign in_sx     = s_axis_tdata[POS_W-1:0];
    assign in_sy     = s_axis_tdata[2*POS_W-1:POS_W];
    assign in_ox     = s_axis_tdata[3*POS_W-1:2*POS_W];
    assign in_oy     = s_axis_tdata[4*POS_W-1:3*POS_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;
    assign out_free      = !r_ovalid || m_axis_tready;

    assign axis_d = r_axis ? r_dym : r_dxm;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DX2: begin
                mul_a = r_dxm;
                mul_b = r_dxm;
            end
            ST_DY2: begin
                mul_a = r_dym;
                mul_b = r_dym;
            end
            ST_C2: begin
                mul_a = r_cutoff;
                mul_b = r_cutoff;
            end
            ST_M2: begin
                mul_a = r_min;
                mul_b = r_min;
            end
            ST_PLO: begin
                mul_a = r_e[31:0];
                mul_b = axis_d;
            end
            ST_PHI: begin
                mul_a = r_e[63:32];
                mul_b = axis_d;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One restoring division step; the remainder's top bit covers the 65th bit.
    assign div_sh = {r_rem[62:0], r_num[63]};
    assign div_ge = r_rem[63] || (div_sh >= r_den);

    // One digit-by-digit square root step.
    assign sq_t  = r_quo + r_bit;
    assign sq_ge = (r_rem >= sq_t);

    // Cutoff test and clamp of the squared distance.
    assign clamp_in = (r_sum2 <= {1'b0, r_c2});
    assign clamp_lo = (r_sum2 < {1'b0, r_m2});
    assign clamp_r2 = clamp_lo ? r_m2 : r_sum2[63:0];

    // Sign and magnitude of (r - cutoff).
    assign coef_r    = r_quo[POS_W-1:0];
    assign coef_neg  = (coef_r < r_cutoff);
    assign coef_diff = coef_neg ? (r_cutoff - coef_r) : (coef_r - r_cutoff);

    assign padd_sum = {1'b0, r_num[95:32]} + {1'b0, r_prod};

    // Saturating add of the signed contribution to the selected sum.
    assign acc_sum = r_axis ? r_sum_ay : r_sum_ax;
    assign acc_neg = r_coef_neg ^ (r_axis ? r_yneg : r_xneg);
    assign acc_ext = {{2{acc_sum[ACC_W-1]}}, acc_sum};
    assign acc_mag = {2'b00, r_quo};
    assign acc_t   = acc_neg ? (acc_ext - acc_mag) : (acc_ext + acc_mag);

    always_comb begin
        if (acc_neg) begin
            acc_ovf = r_eovf || r_dovf || (acc_t < SUM_MIN);
            acc_new = acc_ovf ? SUM_MIN[ACC_W-1:0] : acc_t[ACC_W-1:0];
        end else begin
            acc_ovf = r_eovf || r_dovf || (acc_t > SUM_MAX);
            acc_new = acc_ovf ? SUM_MAX[ACC_W-1:0] : acc_t[ACC_W-1:0];
        end
    end

    // Shared multiplier, always registered.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= RST_CUTOFF_DIST;
            r_min    <= RST_MIN_DIST;
            r_mass   <= RST_PARTICLE_MASS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CUTOFF_DIST:   r_cutoff <= i_cfg_data;
                CFG_MIN_DIST:      r_min    <= i_cfg_data;
                CFG_PARTICLE_MASS: r_mass   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer with its control state, sums and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= OP_K;
            r_axis   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_sum_ax <= '0;
            r_sum_ay <= '0;
            r_sat    <= 1'b0;
        end else begin
            // The output register fills with a new result or empties on a transfer.
            if (r_state == ST_DONE && r_last && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (s_axis_tuser) begin
                            r_sum_ax <= '0;
                            r_sum_ay <= '0;
                            r_sat    <= 1'b0;
                        end
                        r_state <= ST_DX2;
                    end
                end
                ST_DX2:   r_state <= ST_DY2;
                ST_DY2:   r_state <= ST_C2;
                ST_C2:    r_state <= ST_M2;
                ST_M2:    r_state <= ST_R2;
                ST_R2:    r_state <= ST_CLAMP;
                ST_CLAMP: begin
                    if (!clamp_in || clamp_r2 == 64'd0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_bit[0]) begin
                        r_state <= ST_COEF;
                    end
                end
                ST_COEF: begin
                    r_op    <= OP_K;
                    r_state <= ST_DCHK;
                end
                ST_DCHK: begin
                    if (r_den == 64'd0 || r_num[127:64] >= r_den) begin
                        r_state <= ST_DPOST;
                    end else begin
                        r_cnt   <= 6'd63;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= ST_DPOST;
                    end
                end
                ST_DPOST: begin
                    case (r_op)
                        OP_K: begin
                            r_op    <= OP_E;
                            r_state <= ST_DCHK;
                        end
                        OP_E: begin
                            r_axis  <= 1'b0;
                            r_state <= ST_AXIS;
                        end
                        default: r_state <= ST_ACC;
                    endcase
                end
                ST_AXIS: begin
                    // An axis without offset contributes nothing.
                    if (axis_d != '0) begin
                        r_state <= ST_PLO;
                    end else if (!r_axis) begin
                        r_axis <= 1'b1;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_PLO:   r_state <= ST_PHI;
                ST_PHI:   r_state <= ST_PADD;
                ST_PADD: begin
                    r_op    <= OP_M;
                    r_state <= ST_DCHK;
                end
                ST_ACC: begin
                    if (r_axis) begin
                        r_sum_ay <= acc_new;
                    end else begin
                        r_sum_ax <= acc_new;
                    end
                    if (acc_ovf) begin
                        r_sat <= 1'b1;
                    end
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= ST_AXIS;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_last || out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers; the sequencer decides when they carry meaning.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_xneg <= (in_ox < in_sx);
                r_yneg <= (in_oy < in_sy);
                r_dxm  <= (in_ox < in_sx) ? (in_sx - in_ox) : (in_ox - in_sx);
                r_dym  <= (in_oy < in_sy) ? (in_sy - in_oy) : (in_oy - in_sy);
                r_last <= s_axis_tlast;
            end
            ST_DY2: r_dx2 <= r_prod;
            ST_C2:  r_dy2 <= r_prod;
            ST_M2:  r_c2  <= r_prod;
            ST_R2: begin
                r_m2   <= r_prod;
                r_sum2 <= {1'b0, r_dx2} + {1'b0, r_dy2};
            end
            ST_CLAMP: begin
                r_r2  <= clamp_r2;
                r_rem <= clamp_r2;
                r_quo <= '0;
                r_bit <= 64'd1 << 62;
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    r_rem <= r_rem - sq_t;
                    r_quo <= (r_quo >> 1) + r_bit;
                end else begin
                    r_quo <= r_quo >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_COEF: begin
                r_coef_neg <= coef_neg;
                r_num      <= {96'd0, coef_diff} << POS_FRAC_BITS;
                r_den      <= {32'd0, coef_r};
            end
            ST_DCHK: begin
                if (r_den == 64'd0 || r_num[127:64] >= r_den) begin
                    r_quo  <= '1;
                    r_dovf <= 1'b1;
                end else begin
                    r_rem  <= r_num[127:64];
                    r_dovf <= 1'b0;
                end
            end
            ST_DIV: begin
                r_rem <= div_ge ? (div_sh - r_den) : div_sh;
                r_quo <= {r_quo[62:0], div_ge};
                r_num <= {r_num[127:64], r_num[62:0], 1'b0};
            end
            ST_DPOST: begin
                case (r_op)
                    OP_K: begin
                        r_eovf <= r_dovf;
                        r_num  <= {64'd0, r_quo} << (POS_FRAC_BITS + 16);
                        r_den  <= {32'd0, r_mass};
                    end
                    OP_E: begin
                        r_e    <= r_quo;
                        r_eovf <= r_eovf || r_dovf;
                    end
                    default: begin
                    end
                endcase
            end
            ST_PHI: begin
                r_num <= {64'd0, r_prod};
                r_den <= r_r2;
            end
            ST_PADD: begin
                r_num[96:32] <= padd_sum;
            end
            ST_DONE: begin
                if (r_last && out_free) begin
                    r_odata <= {r_sum_ay, r_sum_ax};
                    r_osat  <= r_sat;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise repulsive force accumulator testbench
// Streams neighbour pairs into the accumulator, predicts the saturating
// acceleration sums in fixed point alongside it, and compares every emitted
// sum field by field. Directed runs cover the cutoff edge, the distance
// clamp, stage and sum saturation, zero mass and the register extremes.
// Random runs follow under several register settings; all runs see bursty
// input and a stalling output, and one test adds a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import prfa_pkg::*;

    localparam int          FRAC_BITS     = PRFA_POS_FRAC_BITS;
    // A pair inside the cutoff is the slowest kind, and the settle wait is
    // long enough for any pair still in flight to finish.
    localparam int          SETTLE_CYCLES = 400;
    // The slowest correct run is roughly 700 pairs inside the cutoff, plus
    // input gaps, output stalls and the long hold-off.
    // The limit takes that several times over.
    localparam int unsigned RUN_LIMIT     = 2_000_000;
    localparam logic [63:0] ACC_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ACC_MIN       = 64'h8000_0000_0000_0000;
    localparam logic [31:0] POS_MAX       = 32'hFFFF_FFFF;

    // One neighbour pair as it travels on the slave side.
    typedef struct packed {
        logic [31:0] self_x;
        logic [31:0] self_y;
        logic [31:0] other_x;
        logic [31:0] other_y;
        logic        first_pair;
        logic        last_pair;
    } t_pair;

    // One emitted acceleration result.
    typedef struct packed {
        logic [63:0] accel_x;
        logic [63:0] accel_y;
        logic        saturated;
    } t_accel;

    // Ways the output side takes results while it is not held off.
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_TRICKLE
    } t_sink_mode;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [4*POS_W-1:0]   s_axis_tdata  = '0;  // self_x, self_y, other_x, other_y
    logic                 s_axis_tuser  = 1'b0; // first_pair
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [2*ACC_W-1:0]   m_axis_tdata;         // accel_x_out, accel_y_out
    logic                 m_axis_tuser;         // saturated
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    always #5 i_clk = ~i_clk;

    pair_repulsive_force_accumulate uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the running sums.
    // ------------------------------------------------------------------------
    logic [31:0]  cfg_cutoff = RST_CUTOFF_DIST;
    logic [31:0]  cfg_min    = RST_MIN_DIST;
    logic [31:0]  cfg_mass   = RST_PARTICLE_MASS;
    logic [63:0]  pred_sum_x = '0;
    logic [63:0]  pred_sum_y = '0;
    logic         pred_sat   = 1'b0;

    t_accel       expected_accel[$];   // sums still owed by the block, oldest first
    int unsigned  fail_count      = 0;
    int unsigned  cycle_count     = 0;
    int unsigned  burst_left      = 0; // transfers left in the current input burst
    int unsigned  result_hold_req = 0; // long output hold-off asked by a test

    // floor(a * b / d) on a 128-bit product. The top bit flags a zero divisor
    // or a quotient that does not fit 64 bits; the quotient is then all ones.
    function automatic logic [64:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                    logic [63:0] d);
        logic [127:0] prod;
        logic [127:0] quo;
        if (d == 64'd0)
            return {1'b1, {64{1'b1}}};
        prod = {64'd0, a} * {64'd0, b};
        quo  = prod / {64'd0, d};
        if (quo[127:64] != 64'd0)
            return {1'b1, {64{1'b1}}};
        return {1'b0, quo[63:0]};
    endfunction

    // Integer square root, one result bit per step from the top down.
    function automatic logic [31:0] floor_sqrt(logic [63:0] v);
        logic [31:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = {32'd0, root | (32'd1 << b)};
            if (cand * cand <= v)
                root = cand[31:0];
        end
        return root;
    endfunction

    // Adds a signed magnitude to a two's complement sum, clamping at the
    // signed limits. The top bit of the return tells that it clamped; a
    // forced add goes straight to the limit of its sign.
    function automatic logic [64:0] add_saturating(logic [63:0] total, logic [63:0] mag,
                                                   logic neg, logic forced);
        logic [63:0] room;
        if (!neg) begin
            room = ACC_MAX - total;
            if (forced || mag > room)
                return {1'b1, ACC_MAX};
            return {1'b0, total + mag};
        end
        room = total - ACC_MIN;
        if (forced || mag > room)
            return {1'b1, ACC_MIN};
        return {1'b0, total - mag};
    endfunction

    // Applies one accepted pair to the predicted sums and, on the last pair
    // of a run, queues the sums that the block must hand out.
    task automatic accumulate_pair(input t_pair p);
        logic        xneg, yneg, coef_neg, stage_ovf, hit;
        logic [31:0] dxm, dym, root, diff;
        logic [63:0] dx2, dy2, c2, m2, r2;
        logic [64:0] span, kq, eq, mq;
        t_accel      res;
        xneg = p.other_x < p.self_x;
        yneg = p.other_y < p.self_y;
        dxm  = xneg ? p.self_x - p.other_x : p.other_x - p.self_x;
        dym  = yneg ? p.self_y - p.other_y : p.other_y - p.self_y;
        dx2  = {32'd0, dxm} * {32'd0, dxm};
        dy2  = {32'd0, dym} * {32'd0, dym};
        c2   = {32'd0, cfg_cutoff} * {32'd0, cfg_cutoff};
        m2   = {32'd0, cfg_min} * {32'd0, cfg_min};

        if (p.first_pair) begin
            pred_sum_x = '0;
            pred_sum_y = '0;
            pred_sat   = 1'b0;
        end

        // A pair exactly on the cutoff still interacts.
        span = {1'b0, dx2} + {1'b0, dy2};
        if (span <= {1'b0, c2}) begin
            r2 = span[63:0];
            if (r2 < m2)
                r2 = m2;
            if (r2 != 64'd0) begin
                root      = floor_sqrt(r2);
                // Repulsive inside the cutoff, attractive when the clamp
                // pushes the distance past it.
                coef_neg  = root < cfg_cutoff;
                diff      = coef_neg ? cfg_cutoff - root : root - cfg_cutoff;
                kq        = scaled_quotient({32'd0, diff}, 64'd1 << FRAC_BITS,
                                            {32'd0, root});
                eq        = scaled_quotient(kq[63:0], 64'd1 << (FRAC_BITS + 16),
                                            {32'd0, cfg_mass});
                stage_ovf = kq[64] | eq[64];
                // An axis with no offset adds nothing and never saturates.
                if (dxm != 32'd0) begin
                    mq = scaled_quotient(eq[63:0], {32'd0, dxm}, r2);
                    {hit, pred_sum_x} = add_saturating(pred_sum_x, mq[63:0],
                                                       coef_neg != xneg, stage_ovf | mq[64]);
                    pred_sat = pred_sat | hit;
                end
                if (dym != 32'd0) begin
                    mq = scaled_quotient(eq[63:0], {32'd0, dym}, r2);
                    {hit, pred_sum_y} = add_saturating(pred_sum_y, mq[63:0],
                                                       coef_neg != yneg, stage_ovf | mq[64]);
                    pred_sat = pred_sat | hit;
                end
            end
        end

        if (p.last_pair) begin
            res.accel_x   = pred_sum_x;
            res.accel_y   = pred_sum_y;
            res.saturated = pred_sat;
            expected_accel = {expected_accel, res};
        end
    endtask

    // ------------------------------------------------------------------------
    // Pair construction.
    // ------------------------------------------------------------------------
    function automatic t_pair pair_of(logic [31:0] sx, logic [31:0] sy, logic [31:0] ox,
                                      logic [31:0] oy, logic first, logic last);
        t_pair p;
        p.self_x     = sx;
        p.self_y     = sy;
        p.other_x    = ox;
        p.other_y    = oy;
        p.first_pair = first;
        p.last_pair  = last;
        return p;
    endfunction

    // Moves a position by an offset in a random direction, turning around
    // where the first choice would wrap.
    function automatic logic [31:0] offset_pos(logic [31:0] base, logic [31:0] off);
        logic [32:0] up;
        up = {1'b0, base} + {1'b0, off};
        if ($urandom_range(1) == 1 && !up[32])
            return up[31:0];
        if (base >= off)
            return base - off;
        return up[31:0];
    endfunction

    // A pair with fully random self position and a neighbour offset of up
    // to a quarter beyond the cutoff per axis, so that about half interact.
    function automatic t_pair near_pair(logic [31:0] cut);
        t_pair       p;
        logic [32:0] lim;
        logic [31:0] offx, offy;
        lim = {1'b0, cut} + {3'b0, cut[31:2]};
        if (lim[32])
            lim = {1'b0, POS_MAX};
        offx = ($urandom_range(15) == 0) ? 32'd0 : $urandom_range(lim[31:0], 0);
        offy = ($urandom_range(15) == 0) ? 32'd0 : $urandom_range(lim[31:0], 0);
        p.self_x     = $urandom;
        p.self_y     = $urandom;
        p.other_x    = offset_pos(p.self_x, offx);
        p.other_y    = offset_pos(p.self_y, offy);
        p.first_pair = 1'b0;
        p.last_pair  = 1'b0;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. The sender works in bursts of random length with random
    // gaps in between. Each call returns right after the edge at which its
    // transfer was taken, so tvalid is only ever changed once per step.
    // ------------------------------------------------------------------------
    task automatic send_pair(input t_pair p);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(20, 1);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(12, 1);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.other_y, p.other_x, p.self_y, p.self_x};
        s_axis_tuser  <= p.first_pair;
        s_axis_tlast  <= p.last_pair;
        do @(posedge i_clk); while (!s_axis_tready);
        accumulate_pair(p);
    endtask

    // Stops sending, waits for every owed result and then lets any pair that
    // produces no result run out of the block.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_accel.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers back to back while the block is idle.
    task automatic load_force_config(input logic [31:0] cut, input logic [31:0] minv,
                                     input logic [31:0] mass);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CUTOFF_DIST;
        i_cfg_data  <= cut;
        @(posedge i_clk);
        i_cfg_index <= CFG_MIN_DIST;
        i_cfg_data  <= minv;
        @(posedge i_clk);
        i_cfg_index <= CFG_PARTICLE_MASS;
        i_cfg_data  <= mass;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_cutoff = cut;
        cfg_min    = minv;
        cfg_mass   = mass;
    endtask

    // ------------------------------------------------------------------------
    // Output side. Outside a long hold-off the receiver switches between
    // always ready, a coin toss, a one-in-four chance and rare acceptance.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold;
        int unsigned mode_left;
        t_sink_mode  mode;
        mode      = SINK_OPEN;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (result_hold_req != 0) begin
                hold            = result_hold_req;
                result_hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_sink_mode'($urandom_range(3));
                    mode_left = $urandom_range(300, 40);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN: begin
                        m_axis_tready <= 1'b1;
                    end
                    SINK_COIN: begin
                        m_axis_tready <= ($urandom_range(1) == 1);
                    end
                    SINK_SPARSE: begin
                        m_axis_tready <= ($urandom_range(3) == 0);
                    end
                    default: begin
                        m_axis_tready <= ($urandom_range(15) == 0);
                    end
                endcase
            end
        end
    end

    // Each result transfer is matched against the oldest owed sum.
    always @(posedge i_clk) begin : check_accel
        t_accel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_accel.size() == 0) begin
                $display("%0t: result with nothing owed, x %h y %h sat %b", $time,
                         m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser);
                fail_count++;
            end else begin
                want = expected_accel.pop_front();
                if (m_axis_tdata[63:0] !== want.accel_x) begin
                    $display("%0t: accel_x expected %h actual %h", $time,
                             want.accel_x, m_axis_tdata[63:0]);
                    fail_count++;
                end
                if (m_axis_tdata[127:64] !== want.accel_y) begin
                    $display("%0t: accel_y expected %h actual %h", $time,
                             want.accel_y, m_axis_tdata[127:64]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.saturated, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Ends a run that hangs.
    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset register values: far pairs at the field extremes, a pair right on
    // the cutoff and one just past it, the distance clamp, an axis with no
    // offset, a longer run and a last pair that carries on an old sum.
    task automatic test_reset_defaults();
        send_pair(pair_of(32'd0, 32'd0, POS_MAX, POS_MAX, 1'b1, 1'b1));
        send_pair(pair_of(POS_MAX, POS_MAX, 32'd0, 32'd0, 1'b1, 1'b1));
        send_pair(pair_of(32'd1000, 32'd2000, 32'd1000 + RST_CUTOFF_DIST, 32'd2000,
                          1'b1, 1'b1));
        send_pair(pair_of(32'd1000, 32'd2000, 32'd1001 + RST_CUTOFF_DIST, 32'd2000,
                          1'b1, 1'b1));
        send_pair(pair_of(32'd5000, 32'd5000, 32'd6000, 32'd4000, 1'b1, 1'b0));
        send_pair(pair_of(32'd5000, 32'd5000, 32'd5000, 32'd9000, 1'b0, 1'b0));
        send_pair(pair_of(32'd5000, 32'd5000, 32'd5001, 32'd5000, 1'b0, 1'b0));
        send_pair(pair_of(32'd5000, 32'd5000, 32'd3000, 32'd55000, 1'b0, 1'b1));
        send_pair(pair_of(32'd7, 32'd7, 32'd100007, 32'd7, 1'b0, 1'b1));
        drain_results();
    endtask

    // Widest cutoff and heaviest mass: a neighbour across the whole range sits
    // on the cutoff, and close pairs add about 2^62 each so that the sum
    // clamps at both signed limits without any stage overflowing.
    task automatic test_sum_overflow();
        load_force_config(POS_MAX, 32'd1, POS_MAX);
        send_pair(pair_of(32'd0, 32'd9, POS_MAX, 32'd9, 1'b1, 1'b1));
        for (int i = 0; i < 4; i++)
            send_pair(pair_of(32'd100, 32'd100, 32'd102, 32'd100, i == 0, i == 3));
        for (int i = 0; i < 4; i++)
            send_pair(pair_of(32'd102, 32'd100, 32'd100, 32'd100, i == 0, i == 3));
        drain_results();
    endtask

    // Unit mass makes the scaled coefficient overflow, which forces the sum
    // to its limit; a following run clears the flag again.
    task automatic test_stage_overflow();
        load_force_config(POS_MAX, 32'd1, 32'd1);
        send_pair(pair_of(32'd100, 32'd100, 32'd102, 32'd100, 1'b1, 1'b0));
        send_pair(pair_of(32'd500, 32'd500, 32'd500, 32'd497, 1'b0, 1'b1));
        send_pair(pair_of(32'd100, 32'd100, 32'd100, 32'd100, 1'b1, 1'b1));
        drain_results();
    endtask

    // The clamp lifts the distance past the cutoff, so the pair attracts.
    task automatic test_min_above_cutoff();
        load_force_config(32'd1000, 32'd50000, RST_PARTICLE_MASS);
        send_pair(pair_of(32'd9000, 32'd9000, 32'd9300, 32'd8600, 1'b1, 1'b1));
        drain_results();
    endtask

    // With no clamp a pair on top of itself adds nothing, and a single step
    // apart gives the shortest possible distance.
    task automatic test_zero_distance();
        load_force_config(RST_CUTOFF_DIST, 32'd0, RST_PARTICLE_MASS);
        send_pair(pair_of(32'd4242, 32'd4242, 32'd4242, 32'd4242, 1'b1, 1'b1));
        send_pair(pair_of(32'd4242, 32'd4242, 32'd4241, 32'd4242, 1'b1, 1'b1));
        drain_results();
    endtask

    // A zero mass makes the divider answer all ones, seen as saturation.
    task automatic test_zero_mass();
        load_force_config(RST_CUTOFF_DIST, RST_MIN_DIST, 32'd0);
        send_pair(pair_of(32'd20000, 32'd20000, 32'd25000, 32'd18000, 1'b1, 1'b1));
        drain_results();
    endtask

    // Smallest cutoff with the largest clamp: only unit offsets interact, and
    // the clamp then pushes the distance to the top of the range.
    task automatic test_register_extremes();
        load_force_config(32'd1, POS_MAX, 32'd1);
        send_pair(pair_of(32'd10, 32'd10, 32'd11, 32'd10, 1'b1, 1'b0));
        send_pair(pair_of(32'd10, 32'd10, 32'd11, 32'd11, 1'b0, 1'b0));
        send_pair(pair_of(32'd10, 32'd10, 32'd10, 32'd9, 1'b0, 1'b1));
        drain_results();
    endtask

    // The receiver holds off for a long stretch while single-pair runs keep
    // coming, so results pile up and the block stops taking pairs.
    task automatic test_backpressure();
        t_pair p;
        load_force_config(RST_CUTOFF_DIST, RST_MIN_DIST, RST_PARTICLE_MASS);
        result_hold_req = 2500;
        for (int i = 0; i < 10; i++) begin
            p            = near_pair(cfg_cutoff);
            p.first_pair = 1'b1;
            p.last_pair  = 1'b1;
            send_pair(p);
        end
        drain_results();
    endtask

    // Mostly well-formed runs of up to six near pairs, the rest single pairs
    // with random flags, half of them at fully random positions.
    task automatic test_random_phase(input logic [31:0] cut, input logic [31:0] minv,
                                     input logic [31:0] mass, input int n_items);
        int    sent;
        int    run_len;
        t_pair p;
        load_force_config(cut, minv, mass);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                run_len = $urandom_range(6, 1);
                for (int i = 0; i < run_len; i++) begin
                    p = near_pair(cut);
                    p.first_pair = (i == 0);
                    p.last_pair  = (i == run_len - 1);
                    send_pair(p);
                end
                sent += run_len;
            end else begin
                if ($urandom_range(1) == 1) begin
                    p = near_pair(cut);
                end else begin
                    p = pair_of($urandom, $urandom, $urandom, $urandom, 1'b0, 1'b0);
                end
                p.first_pair = 1'($urandom_range(1));
                p.last_pair  = 1'($urandom_range(1));
                send_pair(p);
                sent++;
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_sum_overflow();
        test_stage_overflow();
        test_min_above_cutoff();
        test_zero_distance();
        test_zero_mass();
        test_register_extremes();
        test_backpressure();

        // Reset values, the widest settings, a light mass that saturates
        // often, a clamp above the cutoff, and fully random registers.
        test_random_phase(RST_CUTOFF_DIST, RST_MIN_DIST, RST_PARTICLE_MASS, 130);
        test_random_phase(POS_MAX, 32'd1, POS_MAX, 130);
        test_random_phase($urandom_range(32'h0100_0000, 32'h0001_0000),
                          $urandom_range(32'h0000_8000, 32'd1),
                          $urandom_range(32'h0000_1000, 32'd1), 130);
        test_random_phase(32'h0010_0000, 32'h0030_0000, $urandom_range(32'h00FF_FFFF, 32'd1),
                          130);
        test_random_phase($urandom, $urandom, $urandom_range(POS_MAX, 32'd1), 130);

        drain_results();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
